// ===== rtl/itdas_pkg.sv =====
package itdas_pkg;

   localparam int unsigned PERIOD_W = 26;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned THRESH_W = 8;

   localparam logic [9:0] MS_PER_S = 10'd1000;

   localparam logic [1:0] MODE_A_OFFSET = 2'd1;
   localparam logic [1:0] MODE_B_OFFSET = 2'd2;

   localparam logic [1:0] CSR_IR_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_ON_PERIOD_S   = 2'd1;
   localparam logic [1:0] CSR_FULL_PERIOD_S = 2'd2;
   localparam logic [1:0] CSR_DELAY_MS      = 2'd3;

   typedef struct packed {
      logic                armed;
      logic                running;
      logic [TIME_W-1:0]   start_time;
      logic                first_is_b;
      logic [OFFSET_W-1:0] active_offset;
      logic                drive_a;
      logic                drive_b;
   } seq_state_type;

   typedef struct packed {
      logic [THRESH_W-1:0] ir_threshold;
      logic [PERIOD_W-1:0] on_ms;
      logic [PERIOD_W-1:0] full_ms;
      logic [OFFSET_W-1:0] delay_ms;
   } seq_cfg_type;

endpackage

// ===== rtl/ir_triggered_dual_actuator_sequencer.sv =====
// ir-triggered dual actuator sequencer, one tentacle
//
// req channel: one beat per tick carrying the time in ms, an ir sample and
// the mode. rsp channel: one beat per req beat with both drive levels and
// the busy flag, taken after that tick's update.
// csr port: write-only registers, one write per clock when csr_wen is high
// (0 ir threshold, 1 on period s, 2 full period s, 3 delay ms). periods are
// scaled to ms in the csr register, so a write takes effect from the next clock.
// a req beat goes from the input register to the result register (rsp_tvalid).
// throughput: one beat per clock while rsp_tready stays high; the input
// register feeds the sequencing logic, which updates its state and loads
// the result register in the same clock.
// when rsp_tready is low the result register holds its beat, the input
// register takes one more beat and then req_tready drops until rsp drains.
// reset: synchronous, clears both registers' valid flags, disarms, stops
// any cycle, switches both drives off and loads the register defaults
// (threshold 128, on 3 s, full 10 s, delay 0).
module ir_triggered_dual_actuator_sequencer
   import itdas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // now_ms[31:0], ir_level[39:32], mode[41:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // drive_a[0], drive_b[1], busy_res[2]
   input  logic        csr_wen,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   seq_cfg_type         cfg_ff;
   seq_cfg_type         cfg_in;
   seq_state_type       state_ff;
   seq_state_type       state_in;

   logic                in_valid_ff;
   logic [TIME_W-1:0]   in_now_ff;
   logic [THRESH_W-1:0] in_ir_ff;
   logic [1:0]          in_mode_ff;

   logic                out_valid_ff;
   logic [2:0]          out_data_ff;

   logic                advance;
   logic                req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // csr writes, periods stored in ms
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            CSR_IR_THRESHOLD:  cfg_in.ir_threshold = csr_wdata[THRESH_W-1:0];
            CSR_ON_PERIOD_S:   cfg_in.on_ms   = PERIOD_W'(csr_wdata) * PERIOD_W'(MS_PER_S);
            CSR_FULL_PERIOD_S: cfg_in.full_ms = PERIOD_W'(csr_wdata) * PERIOD_W'(MS_PER_S);
            CSR_DELAY_MS:      cfg_in.delay_ms = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ir_threshold <= 8'd128;
         cfg_ff.on_ms        <= PERIOD_W'(3000);
         cfg_ff.full_ms      <= PERIOD_W'(10000);
         cfg_ff.delay_ms     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   itdas_core u_core (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .now_ms     (in_now_ff),
      .ir_level   (in_ir_ff),
      .mode       (in_mode_ff),
      .state_next (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_now_ff  <= req_tdata[31:0];
         in_ir_ff   <= req_tdata[39:32];
         in_mode_ff <= req_tdata[41:40];
      end
      if (advance) begin
         out_data_ff <= {state_in.running, state_in.drive_b, state_in.drive_a};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_data_ff};

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("sequencer state changed without a beat moving");

   a_start_latch: assert property (@(posedge clock) disable iff (reset)
      advance && !state_ff.running && state_in.running
      |=> state_ff.start_time == $past(in_now_ff))
      else $error("start time not taken from the starting beat");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_now_ff))
      else $error("held input beat lost or overwritten");

   a_busy_match: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_data_ff[2] == state_ff.running)
      else $error("busy flag differs from running state");

endmodule

// ===== rtl/itdas_core.sv =====
module itdas_core
   import itdas_pkg::*;
(
   input  seq_state_type       state,
   input  seq_cfg_type         cfg,
   input  logic [TIME_W-1:0]   now_ms,
   input  logic [THRESH_W-1:0] ir_level,
   input  logic [1:0]          mode,
   output seq_state_type       state_next
);

   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] on_ms_ext;
   logic [TIME_W-1:0] full_off;
   logic [TIME_W-1:0] on_off;
   logic [TIME_W-1:0] offset_ext;

   assign elapsed    = now_ms - state.start_time;
   assign on_ms_ext  = {{(TIME_W-PERIOD_W){1'b0}}, cfg.on_ms};
   assign offset_ext = {{(TIME_W-OFFSET_W){1'b0}}, state.active_offset};
   assign full_off   = {{(TIME_W-PERIOD_W){1'b0}}, cfg.full_ms} + offset_ext;
   assign on_off     = on_ms_ext + offset_ext;

   always_comb begin
      state_next = state;
      if (ir_level > cfg.ir_threshold) begin
         state_next.armed = 1'b1;
      end
      if (state_next.armed) begin
         if (!state.running) begin
            state_next.first_is_b    = (mode == MODE_B_OFFSET);
            state_next.active_offset = (mode == MODE_A_OFFSET || mode == MODE_B_OFFSET)
                                       ? cfg.delay_ms : '0;
            state_next.running       = 1'b1;
            state_next.start_time    = now_ms;
            if (mode == MODE_B_OFFSET) begin
               state_next.drive_b = 1'b1;
            end else begin
               state_next.drive_a = 1'b1;
            end
         end else if (elapsed > full_off) begin
            state_next.running = 1'b0;
            state_next.armed   = 1'b0;
         end else if (elapsed > on_off) begin
            state_next.drive_a = 1'b0;
            state_next.drive_b = 1'b0;
         end else if (elapsed > on_ms_ext) begin
            if (state.first_is_b) begin
               state_next.drive_b = 1'b0;
            end else begin
               state_next.drive_a = 1'b0;
            end
         end else if (elapsed > offset_ext) begin
            if (state.first_is_b) begin
               state_next.drive_a = 1'b1;
            end else begin
               state_next.drive_b = 1'b1;
            end
         end
      end
   end

endmodule

// ===== tb/sv/ir_triggered_dual_actuator_sequencer_tb.sv =====
module ir_triggered_dual_actuator_sequencer_tb
   import itdas_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  ir_level;
      logic [31:0] now_ms;
   } tick_beat_type;

   typedef struct {
      logic drive_a;
      logic drive_b;
      logic busy;
   } drive_levels_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // now_ms[31:0], ir_level[39:32], mode[41:40]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // drive_a[0], drive_b[1], busy_res[2]
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   tick_beat_type    tick_queue[$];
   drive_levels_type levels_due[$];

   int unsigned sent_count = 0;
   int unsigned checked_count = 0;
   int unsigned mismatches = 0;
   bit          steady = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;

   // register copies
   logic [7:0]  thr_reg = 8'd128;
   logic [15:0] on_s_reg = 16'd3;
   logic [15:0] full_s_reg = 16'd10;
   logic [15:0] delay_reg = 16'd0;

   // sequencer copy
   logic        seq_armed = 1'b0;
   logic        seq_running = 1'b0;
   logic [31:0] seq_start = '0;
   logic        seq_first_b = 1'b0;
   logic [15:0] seq_offset = '0;
   logic        seq_drive_a = 1'b0;
   logic        seq_drive_b = 1'b0;

   ir_triggered_dual_actuator_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock <= 1'b1;
      #6;
      clock <= 1'b0;
      #6;
   end

   function automatic void set_first(input logic on);
      if (seq_first_b) seq_drive_b = on;
      else seq_drive_a = on;
   endfunction

   function automatic void set_second(input logic on);
      if (seq_first_b) seq_drive_a = on;
      else seq_drive_b = on;
   endfunction

   function automatic void advance_sequencer(input tick_beat_type t);
      logic [31:0]      elapsed;
      logic [31:0]      on_ms;
      logic [31:0]      full_ms;
      drive_levels_type lv;
      if (t.ir_level > thr_reg) seq_armed = 1'b1;
      if (seq_armed) begin
         if (!seq_running) begin
            seq_first_b = (t.mode == MODE_B_OFFSET);
            seq_offset  = (t.mode == MODE_A_OFFSET || t.mode == MODE_B_OFFSET) ?
                          delay_reg : 16'd0;
            seq_running = 1'b1;
            seq_start   = t.now_ms;
            set_first(1'b1);
         end else begin
            elapsed = t.now_ms - seq_start;
            on_ms   = 32'(on_s_reg) * 32'd1000;
            full_ms = 32'(full_s_reg) * 32'd1000;
            if (elapsed > full_ms + 32'(seq_offset)) begin
               seq_running = 1'b0;
               seq_armed   = 1'b0;
            end else if (elapsed > on_ms + 32'(seq_offset)) begin
               set_first(1'b0);
               set_second(1'b0);
            end else if (elapsed > on_ms) begin
               set_first(1'b0);
            end else if (elapsed > 32'(seq_offset)) begin
               set_second(1'b1);
            end
         end
      end
      lv.drive_a = seq_drive_a;
      lv.drive_b = seq_drive_b;
      lv.busy    = seq_running;
      levels_due.push_back(lv);
   endfunction

   // driver
   always @(posedge clock) begin
      tick_beat_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_sequencer(tick_beat_type'(req_tdata[41:0]));
         end
         if (!req_tvalid || req_tready) begin
            if (tick_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 38)) begin
               nxt = tick_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'd0, nxt};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      drive_levels_type lv;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (levels_due.size() == 0) begin
               $error("unexpected rsp beat: tdata %0h", rsp_tdata);
               mismatches++;
            end else begin
               lv = levels_due.pop_front();
               if (rsp_tdata[0] !== lv.drive_a) begin
                  $error("drive_a: expected %0b, got %0b", lv.drive_a, rsp_tdata[0]);
                  mismatches++;
               end
               if (rsp_tdata[1] !== lv.drive_b) begin
                  $error("drive_b: expected %0b, got %0b", lv.drive_b, rsp_tdata[1]);
                  mismatches++;
               end
               if (rsp_tdata[2] !== lv.busy) begin
                  $error("busy_res: expected %0b, got %0b", lv.busy, rsp_tdata[2]);
                  mismatches++;
               end
            end
            checked_count++;
         end
         // long back-pressure while the sender keeps offering
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && tick_queue.size() > 20) begin
            hold_done = 1'b1;
            hold_left = 300;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 38);
         end
      end
   end

   task automatic send_tick(input logic [31:0] now, input logic [7:0] ir,
                            input logic [1:0] mode);
      tick_beat_type t;
      t.now_ms   = now;
      t.ir_level = ir;
      t.mode     = mode;
      tick_queue.push_back(t);
      sent_count++;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_IR_THRESHOLD:  thr_reg    = value[7:0];
         CSR_ON_PERIOD_S:   on_s_reg   = value;
         CSR_FULL_PERIOD_S: full_s_reg = value;
         CSR_DELAY_MS:      delay_reg  = value;
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [7:0] thr, input logic [15:0] on_s,
                           input logic [15:0] full_s, input logic [15:0] dly);
      write_reg(CSR_IR_THRESHOLD, {8'd0, thr});
      write_reg(CSR_ON_PERIOD_S, on_s);
      write_reg(CSR_FULL_PERIOD_S, full_s);
      write_reg(CSR_DELAY_MS, dly);
      @(posedge clock);
      csr_wen <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (checked_count < sent_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [31:0] base;
      logic [31:0] clock_ms;
      logic [31:0] now;
      logic [31:0] scale;
      logic [31:0] span_s;
      logic [7:0]  thr;
      logic [7:0]  ir;
      logic [15:0] on_s;
      logic [15:0] full_s;
      logic [15:0] dly;
      int unsigned roll;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // default registers: threshold edge, offsetless cycle, wrap at start
      send_tick(32'd0, 8'd128, 2'd0);
      send_tick(32'd5, 8'd129, 2'd0);
      send_tick(32'd100, 8'd0, 2'd3);
      send_tick(32'd3005, 8'd0, 2'd0);
      send_tick(32'd3006, 8'd0, 2'd0);
      send_tick(32'd10005, 8'd0, 2'd0);
      send_tick(32'd10006, 8'd0, 2'd1);
      send_tick(32'd10010, 8'd0, 2'd2);
      send_tick(32'hFFFF_FFFF, 8'd255, 2'd1);
      send_tick(32'h0000_0010, 8'd0, 2'd1);
      wait_drained();

      // registers changed while a cycle runs, then b first with offset
      set_regs(8'd0, 16'd1, 16'd2, 16'd500);
      base = 32'h8000_0001;
      send_tick(32'h8000_0000, 8'd1, 2'd2);
      send_tick(base, 8'd1, 2'd2);
      send_tick(base + 32'd400, 8'd0, 2'd0);
      send_tick(base + 32'd600, 8'd0, 2'd0);
      send_tick(base + 32'd1200, 8'd0, 2'd0);
      send_tick(base + 32'd1600, 8'd0, 2'd0);
      send_tick(base + 32'd2600, 8'd0, 2'd0);
      wait_drained();

      // full period shorter than on period: drives left on after the end
      set_regs(8'd0, 16'd3, 16'd1, 16'd0);
      send_tick(32'd1000, 8'd1, 2'd0);
      send_tick(32'd1500, 8'd0, 2'd0);
      send_tick(32'd2100, 8'd0, 2'd0);
      send_tick(32'd2200, 8'd0, 2'd0);
      wait_drained();

      set_regs(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(32'd0, 8'd255, 2'd1);
      send_tick(32'hFFFF_FFFF, 8'd255, 2'd2);
      wait_drained();

      // zero periods, time going backwards
      set_regs(8'd0, 16'd0, 16'd0, 16'd0);
      send_tick(32'd50, 8'd255, 2'd2);
      send_tick(32'd50, 8'd0, 2'd3);
      send_tick(32'd49, 8'd0, 2'd0);
      wait_drained();

      clock_ms = 32'd0;
      for (int phase = 0; phase < 8; phase++) begin
         steady = (phase == 2);
         if ($urandom_range(0, 4) == 0) begin
            thr    = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            on_s   = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
            full_s = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
            dly    = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
            if (thr == 8'd255) thr = 8'd254;
         end else begin
            thr    = 8'($urandom_range(0, 255));
            on_s   = 16'($urandom_range(0, 3));
            full_s = 16'($urandom_range(0, 4));
            dly    = 16'($urandom_range(0, 3000));
         end
         if (phase == 5) thr = 8'd255;
         set_regs(thr, on_s, full_s, dly);
         if ($urandom_range(0, 2) == 0) clock_ms = 32'hFFFF_F000;
         span_s = (full_s > on_s) ? 32'(full_s) : 32'(on_s);
         scale  = (span_s * 32'd1000 + 32'(dly)) / 6 + 32'd20;
         for (int n = 0; n < 55; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) now = $urandom();
            else if (roll < 12) now = clock_ms - $urandom_range(1, 50);
            else now = clock_ms + $urandom_range(0, scale);
            clock_ms = now;
            roll = $urandom_range(0, 99);
            if (roll < 10) ir = thr;
            else if (roll < 70 && thr != 8'd255) ir = 8'($urandom_range(thr + 1, 255));
            else ir = 8'($urandom_range(0, 255));
            send_tick(now, ir, 2'($urandom_range(0, 3)));
         end
         wait_drained();
      end
      steady = 1'b0;

      if (levels_due.size() != 0) begin
         $error("%0d rsp beats never arrived", levels_due.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
